FILE: sv/gcss_pkg.sv
// Shared types and constants for the grouped count / sum / sum-of-squares unit.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package gcss_pkg;

    localparam int KIND_W   = 1;
    localparam int GID_W    = 10;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int SQ_W     = 64;
    localparam int ENTRY_W  = CNT_W + SUM_W + SQ_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int LIMIT_W    = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // Item kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LIMIT = 8'd1;

    typedef enum logic [1:0] {
        MODE_COUNT  = 2'd0,
        MODE_SUM    = 2'd1,
        MODE_AVG    = 2'd2,
        MODE_STDDEV = 2'd3
    } t_agg_mode;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;   // write one zero entry of the clearing pass
        logic load;     // capture the input word and start the store read
        logic exec;     // update the entry or emit the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pass is at its last entry
        logic stall;    // result word cannot be placed yet
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/grouped_count_sum_sumsq_unit.sv
// Top level of the grouped count / sum / sum-of-squares unit.
// Depends on gcss_pkg, gcss_ctrl, gcss_dp (which holds gcss_ram).
`default_nettype none

// Per-group aggregation over a stream of words. A row word (kind 0) adds one
// to its group's count, its signed value to the group's 64-bit sum and the
// value's square to the 64-bit sum of squares; agg_mode picks which of the
// three run (count; sum; avg = count and sum; stddev = all three). A read
// word (kind 1) returns the group's three totals with group_ok set and clears
// the group. Group ids at or above group_limit (or GROUPS) are dropped on
// rows and read back as zeros with group_ok low. Totals wrap.
// Timing: each accepted word goes through the accept cycle (store read
// issued, value squared) and then a read-modify-write on the single store;
// no new word is taken until that update is done. A read word holds in its
// update cycle while the previous result word is still waiting on the output.
// After reset every group entry in the store is swept to zero, one group per
// cycle; no input word is taken during the sweep, configuration writes are.
// Write configuration only while the unit is idle.
module grouped_count_sum_sumsq_unit #(
    parameter int GROUPS = 1024
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // configuration write channel
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire         [gcss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire         [gcss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input word channel
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire         [gcss_pkg::KIND_W-1:0]      i_kind,
    input  wire         [gcss_pkg::GID_W-1:0]       i_group_id,
    input  wire  signed [gcss_pkg::VAL_W-1:0]       i_row_value,
    // result word channel
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic        [gcss_pkg::CNT_W-1:0]       o_total_count,
    output logic signed [gcss_pkg::SUM_W-1:0]       o_total_sum,
    output logic        [gcss_pkg::SQ_W-1:0]        o_total_sum_sq,
    output logic                                    o_group_ok
);

    gcss_pkg::t_cmd  cmd;
    gcss_pkg::t_stat stat;

    // Config registers take a write on any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencing: sweep, accept, update.
    gcss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Store, arithmetic and result register.
    gcss_dp #(
        .GROUPS (GROUPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_group_id     (i_group_id),
        .i_row_value    (i_row_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_total_count  (o_total_count),
        .o_total_sum    (o_total_sum),
        .o_total_sum_sq (o_total_sum_sq),
        .o_group_ok     (o_group_ok)
    );

endmodule

`default_nettype wire

FILE: sv/gcss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/gcss_ctrl.sv
// Controller for the grouped aggregation unit: clearing pass, accept, update.
// Depends on gcss_pkg.
`default_nettype none

module gcss_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire gcss_pkg::t_stat i_stat,
    output gcss_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted word always goes through its update state before the next one.
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

endmodule

`default_nettype wire

FILE: sv/gcss_dp.sv
// Datapath for the grouped aggregation unit: config registers, squarer,
// accumulator store with read-modify-write, result register.
// Depends on gcss_pkg and gcss_ram.
`default_nettype none

module gcss_dp #(
    parameter int GROUPS = 1024
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire gcss_pkg::t_cmd                     i_cmd,
    output gcss_pkg::t_stat                         o_stat,
    input  wire                                     i_cfg_valid,
    input  wire         [gcss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire         [gcss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire         [gcss_pkg::KIND_W-1:0]      i_kind,
    input  wire         [gcss_pkg::GID_W-1:0]       i_group_id,
    input  wire  signed [gcss_pkg::VAL_W-1:0]       i_row_value,
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic        [gcss_pkg::CNT_W-1:0]       o_total_count,
    output logic signed [gcss_pkg::SUM_W-1:0]       o_total_sum,
    output logic        [gcss_pkg::SQ_W-1:0]        o_total_sum_sq,
    output logic                                    o_group_ok
);

    localparam int AW = $clog2(GROUPS);
    localparam int CW = gcss_pkg::CNT_W;
    localparam int SW = gcss_pkg::SUM_W;
    localparam int QW = gcss_pkg::SQ_W;

    // Configuration
    gcss_pkg::t_agg_mode              r_agg_mode;
    logic [gcss_pkg::LIMIT_W-1:0]     r_group_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agg_mode    <= gcss_pkg::MODE_COUNT;
            r_group_limit <= gcss_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gcss_pkg::CFG_AGG_MODE) begin
                r_agg_mode <= gcss_pkg::t_agg_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_index == gcss_pkg::CFG_GROUP_LIMIT) begin
                r_group_limit <= i_cfg_data[gcss_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Input capture and squarer
    logic                 r_kind;
    logic [AW-1:0]        r_addr;
    logic signed [31:0]   r_value;
    logic [QW-1:0]        r_sq;
    logic                 r_ok;
    logic [31:0]          mag;
    logic                 ok_now;

    assign mag    = i_row_value[31] ? (~i_row_value + 32'd1) : i_row_value;
    assign ok_now = (32'(i_group_id) < 32'(r_group_limit)) &&
                    (32'(i_group_id) < 32'(GROUPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind[0];
            r_addr  <= AW'(i_group_id);
            r_value <= i_row_value;
            r_sq    <= QW'(mag) * QW'(mag);
            r_ok    <= ok_now;
        end
    end

    // Clearing pass counter
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Accumulator store: {squares, sum, count}
    logic [gcss_pkg::ENTRY_W-1:0] rd_entry;
    logic [gcss_pkg::ENTRY_W-1:0] wr_entry;
    logic [AW-1:0]                waddr;
    logic                         we;
    logic [CW-1:0]                cur_cnt;
    logic [SW-1:0]                cur_sum;
    logic [QW-1:0]                cur_sq;
    logic [CW-1:0]                upd_cnt;
    logic [SW-1:0]                upd_sum;
    logic [QW-1:0]                upd_sq;
    logic                         do_count;
    logic                         do_sum;
    logic                         do_sq;
    logic                         is_read;

    assign cur_cnt = rd_entry[CW-1:0];
    assign cur_sum = rd_entry[CW+SW-1:CW];
    assign cur_sq  = rd_entry[CW+SW+QW-1:CW+SW];

    assign do_count = (r_agg_mode != gcss_pkg::MODE_SUM);
    assign do_sum   = (r_agg_mode != gcss_pkg::MODE_COUNT);
    assign do_sq    = (r_agg_mode == gcss_pkg::MODE_STDDEV);
    assign is_read  = (r_kind == gcss_pkg::KIND_READ);

    assign upd_cnt = do_count ? cur_cnt + CW'(1) : cur_cnt;
    assign upd_sum = do_sum ? cur_sum + SW'(r_value) : cur_sum;
    assign upd_sq  = do_sq ? cur_sq + r_sq : cur_sq;

    always_comb begin
        if (i_cmd.clr_wr) begin
            we       = 1'b1;
            waddr    = r_clr_addr;
            wr_entry = '0;
        end else begin
            we       = i_cmd.exec && r_ok;
            waddr    = r_addr;
            wr_entry = is_read ? '0 : {upd_sq, upd_sum, upd_cnt};
        end
    end

    gcss_ram #(
        .WIDTH (gcss_pkg::ENTRY_W),
        .DEPTH (GROUPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.load),
        .i_raddr (AW'(i_group_id)),
        .o_rdata (rd_entry)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.exec && is_read) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_read) begin
            o_total_count  <= r_ok ? cur_cnt : '0;
            o_total_sum    <= r_ok ? cur_sum : '0;
            o_total_sum_sq <= r_ok ? cur_sq : '0;
            o_group_ok     <= r_ok;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(GROUPS - 1));
    assign o_stat.stall    = is_read && o_out_valid && !i_out_ready;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_read) |-> !(o_out_valid && !i_out_ready))
        else $error("result word overwritten before it was taken");

    a_port_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && i_cmd.load))
        else $error("store read and write in the same cycle");

    a_bad_group_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_group_ok) |->
        (o_total_count == '0 && o_total_sum == '0 && o_total_sum_sq == '0))
        else $error("out-of-range read carries nonzero totals");

endmodule

`default_nettype wire
